// ----- design/mbl_pkg.sv -----
// ----------------------------------------------------------------------------
// mbl_pkg
// Shared constants, types and command/status structs of the mirrored-border
// line FIR.
// ----------------------------------------------------------------------------
package mbl_pkg;

   localparam int MAX_RADIUS = 5;
   localparam int MAX_LINE   = 4096;
   localparam int TAPS       = 2 * MAX_RADIUS + 1;
   localparam int NUM_COEF   = 6;
   localparam int NUM_REGS   = NUM_COEF + 1;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int LEN_W      = 13;
   localparam int DATA_W     = 32;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int ADDR_W     = REG_IDX_W + 2;
   localparam int POS_W      = $clog2(MAX_LINE);
   localparam int TAP_POS_W  = POS_W + 2;
   localparam int IDX_W      = $clog2(TAPS);
   localparam int STEP_W     = IDX_W;
   localparam int OFS_W      = $clog2(MAX_RADIUS + 1);
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + $clog2(TAPS);
   localparam int FRAC_W     = 15;

   localparam logic [COEF_W-1:0] COEF_CENTER_RESET = COEF_W'(32768);
   localparam logic [LEN_W-1:0]  LINE_LENGTH_RESET = LEN_W'(1024);

   typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_array_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_COEF_CENTER,
      REG_COEF_OFF1,
      REG_COEF_OFF2,
      REG_COEF_OFF3,
      REG_COEF_OFF4,
      REG_COEF_OFF5,
      REG_LINE_LENGTH
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN_FETCH,
      ST_DRAIN_MUL,
      ST_STORE
   } ctrl_state_type;

   typedef struct packed {
      logic              accept;
      logic              acc_clear;
      logic              mac_issue;
      logic [STEP_W-1:0] step;
      logic [OFS_W-1:0]  offset;
      logic              load_out;
      logic              out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic line_done;
      logic pos_ge_radius;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/mbl_csr.sv -----
// ----------------------------------------------------------------------------
// mbl_csr
// APB register file: tap weights and line length, with length clamping.
// ----------------------------------------------------------------------------
module mbl_csr
   import mbl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready,
   output coef_array_type      coef,
   output logic [LEN_W-1:0]    eff_len
);

   coef_array_type   coef_ff, coef_in;
   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic             wr_en;
   reg_index_type    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = reg_index_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      coef_in        = coef_ff;
      line_length_in = line_length_ff;
      prdata         = '0;
      unique case (reg_idx)
         REG_COEF_CENTER, REG_COEF_OFF1, REG_COEF_OFF2,
         REG_COEF_OFF3, REG_COEF_OFF4, REG_COEF_OFF5: begin
            prdata = DATA_W'(coef_ff[reg_idx]);
            if (wr_en) begin
               coef_in[reg_idx] = pwdata[COEF_W-1:0];
            end
         end
         REG_LINE_LENGTH: begin
            prdata = DATA_W'(line_length_ff);
            if (wr_en) begin
               line_length_in = pwdata[LEN_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff        <= '0;
         coef_ff[0]     <= COEF_CENTER_RESET;
         line_length_ff <= LINE_LENGTH_RESET;
      end else begin
         coef_ff        <= coef_in;
         line_length_ff <= line_length_in;
      end
   end

   always_comb begin
      eff_len = line_length_ff;
      if (32'(line_length_ff) > MAX_LINE) begin
         eff_len = LEN_W'(MAX_LINE);
      end
      if (32'(eff_len) < TAPS) begin
         eff_len = LEN_W'(TAPS);
      end
   end

   assign coef = coef_ff;

endmodule

// ----- design/mbl_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbl_ctrl
// Sequencer: accepts samples, steps the shared MAC over the taps of each
// output and hands finished sums to the output register.
// ----------------------------------------------------------------------------
module mbl_ctrl
   import mbl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic              flush_ff, flush_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         offset_ff <= '0;
         flush_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         offset_ff <= offset_in;
         flush_ff  <= flush_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      offset_in     = offset_ff;
      flush_in      = flush_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.step      = step_ff;
      cmd.offset    = offset_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && (status.line_done || status.pos_ge_radius)) begin
               flush_in      = status.line_done;
               offset_in     = OFS_W'(MAX_RADIUS);
               step_in       = '0;
               cmd.acc_clear = 1'b1;
               state_in      = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (step_ff == STEP_W'(TAPS - 1)) begin
               state_in = ST_DRAIN_FETCH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN_FETCH: begin
            state_in = ST_DRAIN_MUL;
         end
         ST_DRAIN_MUL: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_last = flush_ff && (offset_ff == '0);
               if (flush_ff && (offset_ff != '0)) begin
                  offset_in     = offset_ff - 1'b1;
                  step_in       = '0;
                  cmd.acc_clear = 1'b1;
                  state_in      = ST_MAC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/mbl_dp.sv -----
// ----------------------------------------------------------------------------
// mbl_dp
// Datapath: tap window, line position, mirrored tap addressing, shared
// multiply-accumulate, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module mbl_dp
   import mbl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [SAMPLE_W-1:0] req_sample_in,
   input  coef_array_type      coef,
   input  logic [LEN_W-1:0]    eff_len,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_sample_out,
   output logic                rsp_line_end
);

   logic [SAMPLE_W-1:0] window_ff [TAPS];
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    calc_pos_ff;
   logic [LEN_W-1:0]    len_m1;

   logic signed [TAP_POS_W-1:0] pos_s, tap_s, idx_s;
   logic [IDX_W-1:0]     tap_idx;
   logic [STEP_W-1:0]    tap_dist;
   logic [COEF_W-1:0]    weight;

   logic [SAMPLE_W-1:0] fetch_sample_ff;
   logic [COEF_W-1:0]   fetch_weight_ff;
   logic                fetch_vld_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                prod_vld_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in;

   logic [ACC_W:0]      rounded;
   logic [SAMPLE_W-1:0] sat_sample;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff;
   logic                rsp_line_end_ff;

   // line position and end-of-line detection
   assign len_m1               = eff_len - 1'b1;
   assign status.line_done     = (LEN_W'(pos_ff) >= len_m1);
   assign status.pos_ge_radius = (32'(pos_ff) >= MAX_RADIUS);
   assign status.out_free      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         pos_in = status.line_done ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         calc_pos_ff  <= pos_ff;
         window_ff[0] <= req_sample_in;
         for (int k = 1; k < TAPS; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   // mirrored tap address: left edge not repeated, right edge repeated
   always_comb begin
      pos_s = signed'(TAP_POS_W'(calc_pos_ff));
      tap_s = pos_s + signed'(TAP_POS_W'(cmd.step)) - signed'(TAP_POS_W'(cmd.offset))
              - signed'(TAP_POS_W'(MAX_RADIUS));
      if (tap_s < 0) begin
         idx_s = pos_s + tap_s;
      end else if (tap_s > pos_s) begin
         idx_s = tap_s - pos_s - signed'(TAP_POS_W'(1));
      end else begin
         idx_s = pos_s - tap_s;
      end
      tap_idx = idx_s[IDX_W-1:0];
   end

   always_comb begin
      tap_dist = (32'(cmd.step) >= MAX_RADIUS) ? cmd.step - STEP_W'(MAX_RADIUS)
                                               : STEP_W'(MAX_RADIUS) - cmd.step;
      weight = '0;
      for (int c = 0; c < NUM_COEF; c++) begin
         if (tap_dist == STEP_W'(c)) begin
            weight = coef[c];
         end
      end
   end

   // fetch, multiply, accumulate
   always_ff @(posedge clock) begin
      fetch_sample_ff <= window_ff[tap_idx];
      fetch_weight_ff <= weight;
      prod_ff         <= fetch_sample_ff * fetch_weight_ff;
      acc_ff          <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_vld_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         fetch_vld_ff <= cmd.mac_issue;
         prod_vld_ff  <= fetch_vld_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up, saturate to 16 bits
   assign rounded    = {1'b0, acc_ff} + (ACC_W+1)'(1 << (FRAC_W - 1));
   assign sat_sample = (|rounded[ACC_W:FRAC_W+SAMPLE_W]) ? '1
                                                         : rounded[FRAC_W+SAMPLE_W-1:FRAC_W];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_sample_ff   <= sat_sample;
         rsp_line_end_ff <= cmd.out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_line_end   = rsp_line_end_ff;

endmodule

// ----- design/mirrored_border_line_fir.sv -----
// ----------------------------------------------------------------------------
// mirrored_border_line_fir
// Symmetric 11-tap line FIR with mirrored borders, APB-programmed weights.
//
// Samples of a line enter on req_* (valid/ready), filtered samples leave on
// rsp_* with rsp_line_end set on the last one of a line. The user must write
// weights and line length through the APB port only while the block is idle.
// The block does not enforce this. The first 5 samples of a line give no
// result, each later one gives one, and the last sample flushes 6 results.
// One shared multiplier walks the 11 taps of each output. A sample that
// gives no result is taken and the sequencer stays idle; any other runs the
// tap steps, drain fetch, drain multiply and store, and the last sample of a
// line runs these once per flushed result. No sample is taken meanwhile.
// The result sits in an output register; while it waits, samples that give
// no result are still taken, and the next finished sum waits in the
// sequencer until the register is free.
// Synchronous reset returns weights to their defaults, the line position to
// zero and empties the output register.
// ----------------------------------------------------------------------------
module mirrored_border_line_fir
   import mbl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_sample_out,
   output logic                rsp_line_end,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   coef_array_type   coef;
   logic [LEN_W-1:0] eff_len;
   dp_cmd_type       cmd;
   dp_status_type    status;

   mbl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef),
      .eff_len (eff_len)
   );

   mbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbl_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .coef           (coef),
      .eff_len        (eff_len),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_line_end   (rsp_line_end)
   );

endmodule

// ----- design/mbl_checker.sv -----
// ----------------------------------------------------------------------------
// mbl_checker
// Port-level assertions for the mirrored-border line FIR, bound to the top.
// ----------------------------------------------------------------------------
module mbl_checker
   import mbl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_sample_out,
   input logic                rsp_line_end
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sample_out) && $stable(rsp_line_end))
      else $error("stalled result changed");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("result appeared right after a sample transfer");

   a_line_end_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_line_end |=> !(rsp_valid && rsp_line_end))
      else $error("two line ends in a row");

endmodule

bind mirrored_border_line_fir mbl_checker u_mbl_checker (.*);
